// ----- sv/bresenham_line_generator_macros.svh -----
// assertion macros for the bresenham line generator checker
// expects signals clk and arst_n in the scope of use
`ifndef BRESENHAM_LINE_GENERATOR_MACROS_SVH
`define BRESENHAM_LINE_GENERATOR_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define BLG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define BLG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/blg_pkg.sv -----
// shared types and constants for the bresenham line generator
// no dependencies
package blg_pkg;

	localparam int COORD_BITS  = 6;
	localparam int COLOUR_BITS = 8;
	// error term stays within +-1.5 times the larger span
	localparam int ERR_BITS    = COORD_BITS + 2;
	localparam int E2_BITS     = ERR_BITS + 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic [COLOUR_BITS-1:0]     colour_t;
	typedef logic signed [ERR_BITS-1:0] err_t;

	// one classified line request
	typedef struct packed {
		coord_t  cur_x;
		coord_t  cur_y;
		coord_t  end_x;
		coord_t  end_y;
		colour_t colour;
		coord_t  delta_x;
		coord_t  delta_y;
		logic    step_x_neg;
		logic    step_y_neg;
		err_t    err;
	} req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic {
		WALK_IDLE,
		WALK_RUN
	} walk_state_t;

endpackage

// ----- sv/blg_front.sv -----
// front end: takes a line request and works out spans, directions and initial error
// depends on blg_pkg
module blg_front (
	input  blg_pkg::coord_t  start_x,
	input  blg_pkg::coord_t  start_y,
	input  blg_pkg::coord_t  end_x,
	input  blg_pkg::coord_t  end_y,
	input  blg_pkg::colour_t colour,
	output blg_pkg::req_t    req
);

	blg_pkg::coord_t dx;
	blg_pkg::coord_t dy;

	always_comb begin
		dx = (end_x > start_x) ? end_x - start_x : start_x - end_x;
		dy = (end_y > start_y) ? end_y - start_y : start_y - end_y;
		req.cur_x      = start_x;
		req.cur_y      = start_y;
		req.end_x      = end_x;
		req.end_y      = end_y;
		req.colour     = colour;
		req.delta_x    = dx;
		req.delta_y    = dy;
		// equal coordinates count as a downward step, harmless
		req.step_x_neg = !(start_x < end_x);
		req.step_y_neg = !(start_y < end_y);
		req.err        = signed'(blg_pkg::ERR_BITS'(dx)) - signed'(blg_pkg::ERR_BITS'(dy));
	end

endmodule

// ----- sv/blg_queue.sv -----
// small request queue between front end and walker
// depends on blg_pkg
module blg_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  blg_pkg::req_t        push_data,
	input  logic                 pop,
	output blg_pkg::req_t        pop_data,
	output blg_pkg::q_status_t   status
);

	blg_pkg::req_t                    mem_q [blg_pkg::QUEUE_DEPTH];
	logic [blg_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [blg_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [blg_pkg::QCNT_BITS-1:0]    count_q;

	localparam logic [blg_pkg::QPTR_BITS-1:0] LAST_PTR =
		blg_pkg::QPTR_BITS'(blg_pkg::QUEUE_DEPTH - 1);

	assign status.full  = (count_q == blg_pkg::QCNT_BITS'(blg_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/blg_walker.sv -----
// back end: walks one line a point per cycle, while the output is not stalled, into the output register
// depends on blg_pkg
module blg_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  blg_pkg::req_t       req,
	input  logic                req_avail,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output blg_pkg::coord_t     point_x,
	output blg_pkg::coord_t     point_y,
	output blg_pkg::colour_t    point_colour,
	output logic                last_point
);

	blg_pkg::walk_state_t state_q, state_d;

	blg_pkg::coord_t  x_q, y_q, ex_q, ey_q, dx_q, dy_q, n_q;
	blg_pkg::colour_t colour_q;
	logic             sx_neg_q, sy_neg_q;
	blg_pkg::err_t    err_q;

	logic                              out_valid_q;
	blg_pkg::coord_t                   px_q, py_q;
	blg_pkg::colour_t                  pc_q;
	logic                              plast_q;

	logic                              slot_free;
	logic                              emit;
	logic                              is_last;
	logic                              step_x, step_y;
	logic signed [blg_pkg::E2_BITS-1:0] e2, dx_e, dy_e;
	blg_pkg::coord_t                   x_next, y_next;
	blg_pkg::err_t                     err_next;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		e2       = signed'({err_q, 1'b0});
		dx_e     = signed'(blg_pkg::E2_BITS'(dx_q));
		dy_e     = signed'(blg_pkg::E2_BITS'(dy_q));
		step_x   = (e2 > -dy_e);
		step_y   = (e2 < dx_e);
		x_next   = step_x ? (sx_neg_q ? x_q - 1'b1 : x_q + 1'b1) : x_q;
		y_next   = step_y ? (sy_neg_q ? y_q - 1'b1 : y_q + 1'b1) : y_q;
		err_next = err_q
			- (step_x ? signed'(blg_pkg::ERR_BITS'(dy_q)) : blg_pkg::err_t'(0))
			+ (step_y ? signed'(blg_pkg::ERR_BITS'(dx_q)) : blg_pkg::err_t'(0));
		// end point reached, or the point cap
		is_last  = ((x_q == ex_q) && (y_q == ey_q)) || (n_q == '1);
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			blg_pkg::WALK_IDLE: begin
				if (req_avail) begin
					pop     = 1'b1;
					state_d = blg_pkg::WALK_RUN;
				end
			end
			blg_pkg::WALK_RUN: begin
				if (slot_free) begin
					emit = 1'b1;
					if (is_last) begin
						state_d = blg_pkg::WALK_IDLE;
					end
				end
			end
			default: state_d = blg_pkg::WALK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= blg_pkg::WALK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q      <= req.cur_x;
			y_q      <= req.cur_y;
			ex_q     <= req.end_x;
			ey_q     <= req.end_y;
			dx_q     <= req.delta_x;
			dy_q     <= req.delta_y;
			sx_neg_q <= req.step_x_neg;
			sy_neg_q <= req.step_y_neg;
			err_q    <= req.err;
			colour_q <= req.colour;
			n_q      <= '0;
		end else if (emit) begin
			x_q   <= x_next;
			y_q   <= y_next;
			err_q <= err_next;
			n_q   <= n_q + 1'b1;
		end
		if (emit) begin
			px_q    <= x_q;
			py_q    <= y_q;
			pc_q    <= colour_q;
			plast_q <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_x      = px_q;
	assign point_y      = py_q;
	assign point_colour = pc_q;
	assign last_point   = plast_q;

endmodule

// ----- sv/bresenham_line_generator.sv -----
// bresenham line generator top level: front end, request queue, walker; uses blg_pkg
// path to the first point: queue entry, walker load, output register, when the walker is idle
// throughput: one point per cycle while out_stall is low, max(|dx|,|dy|)+1 points per request,
//   plus a load state in the walker between requests; the walker step loop sets this
// a two-entry queue lets new requests in while a line is still being walked
// reset: arst_n asynchronous active low, empties the queue and the output register
module bresenham_line_generator (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_stall,
	input  blg_pkg::coord_t  start_x,
	input  blg_pkg::coord_t  start_y,
	input  blg_pkg::coord_t  end_x,
	input  blg_pkg::coord_t  end_y,
	input  blg_pkg::colour_t colour,
	// point channel
	output logic             out_valid,
	input  logic             out_stall,
	output blg_pkg::coord_t  point_x,
	output blg_pkg::coord_t  point_y,
	output blg_pkg::colour_t point_colour,
	output logic             last_point
);

	blg_pkg::req_t      front_req;
	blg_pkg::req_t      queue_head;
	blg_pkg::q_status_t q_status;
	logic               push;
	logic               pop;

	// classify the item: spans, step directions, starting error
	blg_front u_front (
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.colour  (colour),
		.req     (front_req)
	);

	// stall only on a full queue, never on the walker directly
	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	blg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_req),
		.pop       (pop),
		.pop_data  (queue_head),
		.status    (q_status)
	);

	// walk the line, one point per free output slot
	blg_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (queue_head),
		.req_avail    (!q_status.empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_colour (point_colour),
		.last_point   (last_point)
	);

endmodule

// ----- sv/blg_checker.sv -----
// port-level checks for the bresenham line generator, bound to the top level
// depends on blg_pkg and bresenham_line_generator_macros.svh
`include "bresenham_line_generator_macros.svh"

module blg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input blg_pkg::coord_t  point_x,
	input blg_pkg::coord_t  point_y,
	input blg_pkg::colour_t point_colour,
	input logic             last_point
);

	logic [2*blg_pkg::COORD_BITS+blg_pkg::COLOUR_BITS:0] point_bits;
	logic                                                 mid_line_take;

	assign point_bits    = {point_x, point_y, point_colour, last_point};
	assign mid_line_take = out_valid && !out_stall && !last_point;

	// a stalled point holds
	`BLG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(point_bits), "stalled point changed")

	// a shown point is fully defined
	`BLG_ASSERT_SAME(a_out_known, out_valid, !$isunknown(point_bits), "unknown point shown")

	// points of one line come back to back
	`BLG_ASSERT_NEXT(a_line_streams, mid_line_take, out_valid, "gap inside a line")

	// a line keeps its colour
	`BLG_ASSERT_NEXT(a_line_colour, mid_line_take, $stable(point_colour), "line colour changed")

endmodule

bind bresenham_line_generator blg_checker u_blg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.point_x      (point_x),
	.point_y      (point_y),
	.point_colour (point_colour),
	.last_point   (last_point)
);
